/* sv/cs_pkg.sv */
// Shared types, constants and the arctangent table for the CORDIC sine/cosine block.
// No dependencies; used by cs_iter and cordic_sine_cosine_top.
`default_nettype none

package cs_pkg;

  localparam int ITERATIONS = 11;
  localparam int AW         = 16;
  localparam int XW         = 17;
  localparam int ZW         = 12;
  localparam int TW         = 17;

  localparam int START_X      = 9949;
  localparam int FULL_TURN    = 3600;
  localparam int HALF_TURN    = 1800;
  localparam int QUARTER_TURN = 900;
  localparam int WRAP_BIAS    = 10 * FULL_TURN + HALF_TURN;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } beat_t;

  function automatic logic signed [ZW-1:0] atan_tenths(input int idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:       val = ZW'(450);
      1:       val = ZW'(266);
      2:       val = ZW'(140);
      3:       val = ZW'(71);
      4:       val = ZW'(36);
      5:       val = ZW'(18);
      6:       val = ZW'(9);
      7:       val = ZW'(4);
      8:       val = ZW'(2);
      9:       val = ZW'(1);
      10:      val = ZW'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

/* sv/cs_iter.sv */
// One registered CORDIC rotation-mode iteration with its valid bit.
// Depends on cs_pkg for the beat type and the arctangent table.
`default_nettype none

module cs_iter #(
  parameter int SHIFT = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_i,
  input  wire cs_pkg::beat_t beat_i,
  output logic               vld_o,
  output cs_pkg::beat_t      beat_o
);
  import cs_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = atan_tenths(SHIFT);

  logic          vld_r;
  beat_t         beat_r;
  beat_t         beat_nxt;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  always_comb begin
    xs = beat_i.x >>> SHIFT;
    ys = beat_i.y >>> SHIFT;
    if (!beat_i.z[ZW-1]) begin
      beat_nxt.x = beat_i.x - ys;
      beat_nxt.y = beat_i.y + xs;
      beat_nxt.z = beat_i.z - ATAN;
    end else begin
      beat_nxt.x = beat_i.x + ys;
      beat_nxt.y = beat_i.y - xs;
      beat_nxt.z = beat_i.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign vld_o  = vld_r;
  assign beat_o = beat_r;

endmodule

`default_nettype wire

/* sv/cordic_sine_cosine_top.sv */
// Top level of the pipelined CORDIC sine/cosine block: angle wrap, fold and iteration chain.
// Depends on cs_pkg and cs_iter.
//
// Usage:
//   Input: drive in_angle (tenths of a degree, signed) and raise start. A beat is
//   taken at every rising edge with start high and busy low. busy is always low,
//   so a new angle may enter in every cycle.
//   Output: out_strobe is high for exactly one cycle with out_sine and out_cosine
//   (Q14, 16384 = 1.0) valid in that cycle. Results leave in the order the
//   angles entered.
//   Pipeline: three stages of angle wrap and fold, then one stage per each of the
//   eleven shift-add iterations.
//   Throughput: one angle per cycle, set by the fully pipelined iteration chain.
//   Reset: rst_n (synchronous, active low) clears every valid bit; results in
//   flight are dropped. The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module cordic_sine_cosine_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [cs_pkg::AW-1:0] in_angle,
  output logic                              out_strobe,
  output logic signed [cs_pkg::AW-1:0]      out_sine,
  output logic signed [cs_pkg::AW-1:0]      out_cosine
);
  import cs_pkg::*;

  logic                 s1_vld_r;
  logic [TW-1:0]        s1_t_r;
  logic [TW-1:0]        s1_t_nxt;
  logic                 s2_vld_r;
  logic signed [ZW-1:0] s2_r_r;
  logic signed [ZW-1:0] s2_r_nxt;
  logic                 s3_vld_r;
  beat_t                s3_beat_r;
  beat_t                s3_beat_nxt;

  logic                 vld_chain [ITERATIONS+1];
  beat_t                beat_chain [ITERATIONS+1];

  assign busy = 1'b0;

  always_comb begin
    s1_t_nxt = TW'(in_angle) + TW'(WRAP_BIAS);
    if (s1_t_nxt >= TW'(16 * FULL_TURN)) s1_t_nxt = s1_t_nxt - TW'(16 * FULL_TURN);
    if (s1_t_nxt >= TW'(8 * FULL_TURN))  s1_t_nxt = s1_t_nxt - TW'(8 * FULL_TURN);
    if (s1_t_nxt >= TW'(4 * FULL_TURN))  s1_t_nxt = s1_t_nxt - TW'(4 * FULL_TURN);
  end

  always_comb begin
    logic [TW-1:0] t;
    t = s1_t_r;
    if (t >= TW'(2 * FULL_TURN)) t = t - TW'(2 * FULL_TURN);
    if (t >= TW'(FULL_TURN))     t = t - TW'(FULL_TURN);
    s2_r_nxt = ZW'(t) - ZW'(HALF_TURN);
  end

  always_comb begin
    s3_beat_nxt.y = '0;
    if (s2_r_r > ZW'(QUARTER_TURN)) begin
      s3_beat_nxt.z = s2_r_r - ZW'(HALF_TURN);
      s3_beat_nxt.x = -XW'(START_X);
    end else if (s2_r_r < -ZW'(QUARTER_TURN)) begin
      s3_beat_nxt.z = s2_r_r + ZW'(HALF_TURN);
      s3_beat_nxt.x = -XW'(START_X);
    end else begin
      s3_beat_nxt.z = s2_r_r;
      s3_beat_nxt.x = XW'(START_X);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_t_r    <= s1_t_nxt;
    s2_r_r    <= s2_r_nxt;
    s3_beat_r <= s3_beat_nxt;
  end

  assign vld_chain[0]  = s3_vld_r;
  assign beat_chain[0] = s3_beat_r;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    cs_iter #(
      .SHIFT (i)
    ) u_iter (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld_chain[i]),
      .beat_i (beat_chain[i]),
      .vld_o  (vld_chain[i+1]),
      .beat_o (beat_chain[i+1])
    );
  end

  assign out_strobe = vld_chain[ITERATIONS];
  assign out_sine   = beat_chain[ITERATIONS].y[AW-1:0];
  assign out_cosine = beat_chain[ITERATIONS].x[AW-1:0];

endmodule

`default_nettype wire
